### hw/rtl/motor_position_speed_pid_core_defines.svh
// Assertion macros used by the motor controller top level.
`ifndef MOTOR_POSITION_SPEED_PID_CORE_DEFINES_SVH
`define MOTOR_POSITION_SPEED_PID_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPSP_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("motor_position_speed_pid_core: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPSP_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("motor_position_speed_pid_core: assertion failed");

`endif

### hw/rtl/mpsp_pkg.sv
// Types, constants and arithmetic helpers of the motor controller.
`default_nettype none

package mpsp_pkg;

    localparam int unsigned GATE_TICKS        = 100;
    localparam int unsigned FILTER_WEIGHT_Q16 = 6554;

    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    localparam logic [15:0]        GATE_TICKS_W = 16'(GATE_TICKS);
    localparam logic signed [32:0] FILT_KEEP    = 33'(65536 - FILTER_WEIGHT_Q16);
    localparam logic signed [32:0] FILT_TAKE    = 33'(FILTER_WEIGHT_Q16);

    localparam logic signed [32:0] BAND_HI   = 33'sd200;
    localparam logic signed [32:0] BAND_LO   = -33'sd200;
    localparam logic signed [15:0] DRIVE_POS = 16'sd1000;
    localparam logic signed [15:0] DRIVE_NEG = -16'sd1000;

    localparam logic [1:0] CMD_POS = 2'd0;
    localparam logic [1:0] CMD_SPD = 2'd1;
    localparam logic [1:0] CMD_CLR = 2'd2;

    localparam logic [2:0] REG_KP_POS  = 3'd0;
    localparam logic [2:0] REG_KI_POS  = 3'd1;
    localparam logic [2:0] REG_KD_POS  = 3'd2;
    localparam logic [2:0] REG_KP_SPD  = 3'd3;
    localparam logic [2:0] REG_KI_SPD  = 3'd4;
    localparam logic [2:0] REG_POS_LIM = 3'd5;
    localparam logic [2:0] REG_SPD_LIM = 3'd6;
    localparam logic [2:0] REG_CTA     = 3'd7;

    localparam logic signed [31:0] CTA_RESET = 32'sd65536;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
    localparam logic signed [65:0] S16_MAX = 66'sd32767;
    localparam logic signed [65:0] S16_MIN = -66'sd32768;

    typedef struct packed {
        logic signed [31:0] kp_pos;
        logic signed [31:0] ki_pos;
        logic signed [31:0] kd_pos;
        logic signed [31:0] kp_spd;
        logic signed [31:0] ki_spd;
        logic [30:0]        pos_lim;
        logic [30:0]        spd_lim;
        logic signed [31:0] cta;
    } t_cfg;

    typedef struct packed {
        logic               go;
        logic               clr;
        logic               trunc;
        logic               last;
        logic signed [32:0] a;
        logic signed [32:0] b;
    } t_mac_req;

    typedef struct packed {
        logic               done;
        logic signed [65:0] acc;
    } t_mac_rsp;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [65:0] trunc_q16(input logic signed [65:0] x);
        logic signed [65:0] bias;
        bias = x[65] ? 66'sd65535 : 66'sd0;
        return (x + bias) >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX) begin
            r = S32_MAX[31:0];
        end else if (x < S32_MIN) begin
            r = S32_MIN[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [65:0] x);
        logic signed [15:0] r;
        if (x > S16_MAX) begin
            r = S16_MAX[15:0];
        end else if (x < S16_MIN) begin
            r = S16_MIN[15:0];
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_int(input logic signed [33:0] v,
                                                     input logic [30:0] lim);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        logic signed [31:0] r;
        hi = $signed({3'b000, lim});
        lo = -hi;
        if (v > hi) begin
            r = hi[31:0];
        end else if (v < lo) begin
            r = lo[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? -v : v;
        return r;
    endfunction

    function automatic logic gate_open(input logic [15:0] now, input logic [15:0] last);
        logic [15:0] d;
        d = now - last;
        return d >= GATE_TICKS_W;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mpsp_in_if.sv
// Input channel of the motor controller: one command beat.
`default_nettype none

interface mpsp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] target_count;
    logic [30:0]        count_tolerance;
    logic signed [31:0] encoder_count;
    logic signed [31:0] encoder_speed;
    logic signed [31:0] target_speed;
    logic [30:0]        speed_tolerance;
    logic [15:0]        now_tick;

    modport source (
        output valid, command, target_count, count_tolerance, encoder_count,
               encoder_speed, target_speed, speed_tolerance, now_tick,
        input  ready
    );

    modport sink (
        input  valid, command, target_count, count_tolerance, encoder_count,
               encoder_speed, target_speed, speed_tolerance, now_tick,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/mpsp_out_if.sv
// Output channel of the motor controller: one drive beat.
`default_nettype none

interface mpsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic               brake;

    modport source (output valid, drive, brake, input ready);
    modport sink (input valid, drive, brake, output ready);
endinterface

`default_nettype wire

### hw/rtl/mpsp_apb_regs.sv
// APB configuration register file of the motor controller.
`default_nettype none

module mpsp_apb_regs import mpsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_pos  <= '0;
            r_cfg.ki_pos  <= '0;
            r_cfg.kd_pos  <= '0;
            r_cfg.kp_spd  <= '0;
            r_cfg.ki_spd  <= '0;
            r_cfg.pos_lim <= '0;
            r_cfg.spd_lim <= '0;
            r_cfg.cta     <= CTA_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_KP_POS:  r_cfg.kp_pos  <= pwdata;
                REG_KI_POS:  r_cfg.ki_pos  <= pwdata;
                REG_KD_POS:  r_cfg.kd_pos  <= pwdata;
                REG_KP_SPD:  r_cfg.kp_spd  <= pwdata;
                REG_KI_SPD:  r_cfg.ki_spd  <= pwdata;
                REG_POS_LIM: r_cfg.pos_lim <= pwdata[30:0];
                REG_SPD_LIM: r_cfg.spd_lim <= pwdata[30:0];
                REG_CTA:     r_cfg.cta     <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KP_POS:  prdata = r_cfg.kp_pos;
            REG_KI_POS:  prdata = r_cfg.ki_pos;
            REG_KD_POS:  prdata = r_cfg.kd_pos;
            REG_KP_SPD:  prdata = r_cfg.kp_spd;
            REG_KI_SPD:  prdata = r_cfg.ki_spd;
            REG_POS_LIM: prdata = {1'b0, r_cfg.pos_lim};
            REG_SPD_LIM: prdata = {1'b0, r_cfg.spd_lim};
            REG_CTA:     prdata = r_cfg.cta;
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/mpsp_mac.sv
// Shared pipelined multiply-accumulate unit with optional Q16 truncation.
`default_nettype none

module mpsp_mac import mpsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_req i_req,
    output t_mac_rsp o_rsp
);

    logic               r_v1;
    logic               r_clr1;
    logic               r_trunc1;
    logic               r_last1;
    logic signed [65:0] r_prod;
    logic               r_v2;
    logic               r_clr2;
    logic               r_last2;
    logic signed [65:0] r_term;
    logic signed [65:0] r_acc;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_req.go;
            r_v2   <= r_v1;
            r_done <= r_v2 && r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= i_req.a * i_req.b;
        r_clr1   <= i_req.clr;
        r_trunc1 <= i_req.trunc;
        r_last1  <= i_req.last;
        r_term   <= r_trunc1 ? trunc_q16(r_prod) : r_prod;
        r_clr2   <= r_clr1;
        r_last2  <= r_last1;
        if (r_v2) begin
            r_acc <= (r_clr2 ? 66'sd0 : r_acc) + r_term;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.acc  = r_acc;

endmodule

`default_nettype wire

### hw/rtl/motor_position_speed_pid_core.sv
// Motor position and speed PID controller, top level.
// One command beat enters on i_in and answers exactly one beat on o_out.
// Command 0 runs the position loop, command 1 the speed loop, command 2
// clears both integrals, and command 3 only answers a zero drive.
// Gains, integral limits and the speed scale sit in APB registers at byte
// address 4*i; the user must write them only while the block is idle, which
// the block does not enforce. All products go through one shared 33 x 33
// multiply-accumulate unit with product, term and accumulator registers,
// issued one per cycle within a dependent group by the sequencer. Clear and
// unused commands answer directly, coarse drive and braking after a check;
// the position PID awaits one product group, the speed loop three in turn.
// i_in.ready is high only while the sequencer is idle.
// The result goes to an output register, so a new item is taken while the
// previous beat still waits; if o_out stays stalled, the next result holds
// in its last state until the register frees.
// Reset clears the integrals, the speed filter, the gate tick, the state, the
// output valid and the APB gains and limits; the speed scale resets to 1.0.
`default_nettype none
`include "motor_position_speed_pid_core_defines.svh"

module motor_position_speed_pid_core import mpsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mpsp_in_if.sink           i_in,
    mpsp_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_PCHK = 17'h00002,
        S_P1   = 17'h00004,
        S_P2   = 17'h00008,
        S_P3   = 17'h00010,
        S_S1   = 17'h00020,
        S_WW   = 17'h00040,
        S_S2   = 17'h00080,
        S_S3   = 17'h00100,
        S_WF   = 17'h00200,
        S_SF   = 17'h00400,
        S_SE   = 17'h00800,
        S_SI   = 17'h01000,
        S_S4   = 17'h02000,
        S_WD   = 17'h04000,
        S_FIN  = 17'h08000,
        S_DONE = 17'h10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_cfg               w_cfg;
    t_mac_req           w_req;
    t_mac_rsp           w_rsp;

    logic signed [32:0] r_err;
    logic [30:0]        r_tol;
    logic signed [31:0] r_spd;
    logic signed [31:0] r_tgt;
    logic [15:0]        r_now;
    logic signed [31:0] r_w;
    logic signed [15:0] r_res_drive;
    logic               r_res_brake;
    logic               r_out_valid;
    logic signed [15:0] r_out_drive;
    logic               r_out_brake;

    logic [15:0]        r_last_gate;
    logic signed [31:0] r_pos_int;
    logic signed [31:0] r_spd_int;
    logic signed [31:0] r_filt;

    logic               w_accept;
    logic               w_load;
    logic               w_gate;
    logic [32:0]        w_abs;
    logic               w_coarse_hi;
    logic               w_coarse_lo;
    logic               w_in_tol;
    logic               w_spd_step;
    logic signed [33:0] w_pos_sum;
    logic signed [33:0] w_spd_sum;
    logic signed [65:0] w_filt_q;

    mpsp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mpsp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_out_drive;
    assign o_out.brake = r_out_brake;

    assign w_gate      = gate_open(r_now, r_last_gate);
    assign w_abs       = abs33(r_err);
    assign w_coarse_hi = r_err > BAND_HI;
    assign w_coarse_lo = r_err < BAND_LO;
    assign w_in_tol    = w_abs <= {2'b00, r_tol};
    assign w_spd_step  = (w_abs >= {2'b00, r_tol}) && w_gate;
    assign w_pos_sum   = $signed({{2{r_pos_int[31]}}, r_pos_int}) + $signed({r_err[32], r_err});
    assign w_spd_sum   = $signed({{2{r_spd_int[31]}}, r_spd_int}) + $signed({r_err[32], r_err});
    assign w_filt_q    = trunc_q16(w_rsp.acc);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.command)
                        CMD_POS: n_state = S_PCHK;
                        CMD_SPD: n_state = S_S1;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PCHK: begin
                if (w_coarse_hi || w_coarse_lo || w_in_tol) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_P1;
                end
            end
            S_P1: n_state = S_P2;
            S_P2: n_state = S_P3;
            S_P3: n_state = S_WD;
            S_S1: n_state = S_WW;
            S_WW: begin
                if (w_rsp.done) begin
                    n_state = S_S2;
                end
            end
            S_S2: n_state = S_S3;
            S_S3: n_state = S_WF;
            S_WF: begin
                if (w_rsp.done) begin
                    n_state = S_SF;
                end
            end
            S_SF: n_state = S_SE;
            S_SE: n_state = S_SI;
            S_SI: n_state = S_S4;
            S_S4: n_state = S_WD;
            S_WD: begin
                if (w_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_req       = '0;
        case (r_state)
            S_P1: begin
                w_req.go  = 1'b1;
                w_req.clr = 1'b1;
                w_req.a   = sx33(w_cfg.kp_pos);
                w_req.b   = r_err;
            end
            S_P2: begin
                w_req.go = 1'b1;
                w_req.a  = sx33(w_cfg.ki_pos);
                w_req.b  = sx33(r_pos_int);
            end
            S_P3: begin
                w_req.go    = 1'b1;
                w_req.trunc = 1'b1;
                w_req.last  = 1'b1;
                w_req.a     = sx33(w_cfg.kd_pos);
                w_req.b     = sx33(r_spd);
            end
            S_S1: begin
                w_req.go    = 1'b1;
                w_req.clr   = 1'b1;
                w_req.trunc = 1'b1;
                w_req.last  = 1'b1;
                w_req.a     = sx33(r_spd);
                w_req.b     = sx33(w_cfg.cta);
            end
            S_S2: begin
                w_req.go  = 1'b1;
                w_req.clr = 1'b1;
                w_req.a   = sx33(r_filt);
                w_req.b   = FILT_KEEP;
            end
            S_S3: begin
                w_req.go   = 1'b1;
                w_req.last = 1'b1;
                w_req.a    = sx33(r_w);
                w_req.b    = FILT_TAKE;
            end
            S_SI: begin
                w_req.go    = 1'b1;
                w_req.clr   = 1'b1;
                w_req.trunc = 1'b1;
                w_req.a     = sx33(w_cfg.kp_spd);
                w_req.b     = r_err;
            end
            S_S4: begin
                w_req.go    = 1'b1;
                w_req.trunc = 1'b1;
                w_req.last  = 1'b1;
                w_req.a     = sx33(w_cfg.ki_spd);
                w_req.b     = sx33(r_spd_int);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last_gate <= '0;
            r_pos_int   <= '0;
            r_spd_int   <= '0;
            r_filt      <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in.command == CMD_CLR)) begin
                        r_pos_int <= '0;
                        r_spd_int <= '0;
                    end
                end
                S_PCHK: begin
                    if (!w_coarse_hi && !w_coarse_lo) begin
                        if (w_in_tol) begin
                            r_pos_int <= '0;
                        end else if (w_gate) begin
                            r_pos_int   <= clamp_int(w_pos_sum, w_cfg.pos_lim);
                            r_last_gate <= r_now;
                        end
                    end
                end
                S_SF: begin
                    r_filt <= w_filt_q[31:0];
                end
                S_SI: begin
                    if (w_spd_step) begin
                        r_spd_int   <= clamp_int(w_spd_sum, w_cfg.spd_lim);
                        r_last_gate <= r_now;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_err       <= $signed({i_in.target_count[31], i_in.target_count})
                             - $signed({i_in.encoder_count[31], i_in.encoder_count});
                r_tol       <= (i_in.command == CMD_SPD) ? i_in.speed_tolerance
                                                         : i_in.count_tolerance;
                r_spd       <= i_in.encoder_speed;
                r_tgt       <= i_in.target_speed;
                r_now       <= i_in.now_tick;
                r_res_drive <= '0;
                r_res_brake <= 1'b0;
            end
            S_PCHK: begin
                if (w_coarse_hi) begin
                    r_res_drive <= DRIVE_POS;
                end else if (w_coarse_lo) begin
                    r_res_drive <= DRIVE_NEG;
                end else if (w_in_tol) begin
                    r_res_drive <= '0;
                    r_res_brake <= 1'b1;
                end
            end
            S_WW: begin
                r_w <= sat32(w_rsp.acc);
            end
            S_SE: begin
                r_err <= $signed({r_tgt[31], r_tgt}) - $signed({r_filt[31], r_filt});
            end
            S_FIN: begin
                r_res_drive <= sat16(trunc_q16(w_rsp.acc));
                r_res_brake <= 1'b0;
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_out_drive <= r_res_drive;
            r_out_brake <= r_res_brake;
        end
    end

    `MPSP_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != S_IDLE)
    `MPSP_ASSERT_IMP(a_mac_done_in_wait, i_clk, i_rst_n, w_rsp.done, (r_state == S_WW) || (r_state == S_WF) || (r_state == S_WD))
    `MPSP_ASSERT_IMP(a_brake_zero_drive, i_clk, i_rst_n, o_out.valid && o_out.brake, o_out.drive == 16'sd0)

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the motor position and speed PID core.
`timescale 1ns / 100ps

module testbench;
    import mpsp_pkg::*;

    localparam logic [1:0]         CMD_UNUSED    = 2'd3;
    localparam logic signed [71:0] Q16_ONE       = 72'sd65536;
    localparam logic signed [71:0] COARSE_BAND   = 72'sd200;
    localparam logic signed [15:0] COARSE_DRIVE  = 16'sd1000;
    localparam logic signed [71:0] FILT_TAKE_W   = 72'(FILTER_WEIGHT_Q16);
    localparam logic signed [71:0] FILT_KEEP_W   = Q16_ONE - FILT_TAKE_W;
    localparam logic signed [71:0] WORD_HI       = 72'sd2147483647;
    localparam logic signed [71:0] WORD_LO       = -72'sd2147483648;
    localparam logic signed [71:0] DRIVE_HI      = 72'sd32767;
    localparam logic signed [71:0] DRIVE_LO      = -72'sd32768;
    localparam logic signed [15:0] DRIVE_TOP     = 16'sh7FFF;
    localparam logic signed [15:0] DRIVE_FLOOR   = 16'sh8000;
    localparam int                 SPEED_SPAN    = 200 * 65536;
    localparam int                 TOL_SPAN      = 20 * 65536;
    localparam int                 CHUNK_ITEMS   = 40;
    localparam int                 SETTLE_CYCLES = 24;
    localparam int                 RUN_LIMIT_NS  = 5000000;

    typedef enum {
        GAINS_MILD,
        GAINS_RANDOM,
        GAINS_TOP,
        GAINS_BOTTOM,
        GAINS_ZERO,
        GAINS_WILD
    } t_gain_set;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] target_count;
        logic [30:0]        count_tolerance;
        logic signed [31:0] encoder_count;
        logic signed [31:0] encoder_speed;
        logic signed [31:0] target_speed;
        logic [30:0]        speed_tolerance;
        logic [15:0]        now_tick;
    } t_motor_cmd;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               brake;
    } t_drive_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mpsp_in_if  cmd_bus ();
    mpsp_out_if drive_bus ();

    motor_position_speed_pid_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (drive_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg               gains;
    logic [15:0]        last_gate_tick;
    logic signed [31:0] pos_integral;
    logic signed [31:0] spd_integral;
    logic signed [31:0] filtered_speed;

    t_motor_cmd    pending_cmds[$];
    t_drive_result expected_drives[$];
    logic          beat_taken = 1'b0;
    int unsigned   src_idle_pct = 0;
    int unsigned   snk_stall_pct = 0;
    logic [15:0]   tick_now = '0;
    int            error_count = 0;
    int            brake_count = 0;
    int            sat_count = 0;
    int            gain_loads = 0;
    int            cmd_counts [4] = '{0, 0, 0, 0};

    function automatic logic signed [71:0] sext72(input logic signed [31:0] v);
        return v;
    endfunction

    function automatic logic signed [71:0] mag72(input logic signed [71:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [71:0] clamp72(input logic signed [71:0] v,
                                                   input logic signed [71:0] lo,
                                                   input logic signed [71:0] hi);
        logic signed [71:0] r;
        r = v;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_drive(input logic signed [71:0] q16_sum);
        logic signed [71:0] q;
        q = clamp72(q16_sum / Q16_ONE, DRIVE_LO, DRIVE_HI);
        return q[15:0];
    endfunction

    function automatic logic gate_due(input logic [15:0] now_t);
        logic [15:0] d;
        d = now_t - last_gate_tick;
        return d >= 16'(GATE_TICKS);
    endfunction

    // Advances the controller state by one command and returns its drive beat.
    function automatic t_drive_result predict_drive(input t_motor_cmd c);
        t_drive_result      r;
        logic signed [71:0] err;
        logic signed [71:0] tol;
        logic signed [71:0] lim;
        logic signed [71:0] w;
        logic signed [71:0] acc;
        r.drive = '0;
        r.brake = 1'b0;
        case (c.command)
            CMD_POS: begin
                err = sext72(c.target_count) - sext72(c.encoder_count);
                tol = $signed({41'd0, c.count_tolerance});
                if (err > COARSE_BAND) begin
                    r.drive = COARSE_DRIVE;
                end else if (err < -COARSE_BAND) begin
                    r.drive = -COARSE_DRIVE;
                end else if (mag72(err) <= tol) begin
                    pos_integral = '0;
                    r.brake = 1'b1;
                end else begin
                    if (gate_due(c.now_tick)) begin
                        lim = $signed({41'd0, gains.pos_lim});
                        acc = clamp72(sext72(pos_integral) + err, -lim, lim);
                        pos_integral = acc[31:0];
                        last_gate_tick = c.now_tick;
                    end
                    acc = sext72(gains.kp_pos) * err
                        + sext72(gains.ki_pos) * sext72(pos_integral)
                        + (sext72(gains.kd_pos) * sext72(c.encoder_speed)) / Q16_ONE;
                    r.drive = to_drive(acc);
                end
            end
            CMD_SPD: begin
                w = (sext72(c.encoder_speed) * sext72(gains.cta)) / Q16_ONE;
                w = clamp72(w, WORD_LO, WORD_HI);
                acc = (sext72(filtered_speed) * FILT_KEEP_W + w * FILT_TAKE_W) / Q16_ONE;
                filtered_speed = acc[31:0];
                err = sext72(c.target_speed) - acc;
                tol = $signed({41'd0, c.speed_tolerance});
                if (mag72(err) >= tol && gate_due(c.now_tick)) begin
                    lim = $signed({41'd0, gains.spd_lim});
                    acc = clamp72(sext72(spd_integral) + err, -lim, lim);
                    spd_integral = acc[31:0];
                    last_gate_tick = c.now_tick;
                end
                acc = (sext72(gains.kp_spd) * err) / Q16_ONE
                    + (sext72(gains.ki_spd) * sext72(spd_integral)) / Q16_ONE;
                r.drive = to_drive(acc);
            end
            CMD_CLR: begin
                pos_integral = '0;
                spd_integral = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Mostly well-formed steps near the PID band; the rest is random noise.
    function automatic t_motor_cmd make_cmd();
        t_motor_cmd  c;
        int unsigned pick;
        int          delta;
        pick = $urandom_range(99);
        delta = int'($urandom_range(500)) - 250;
        tick_now = tick_now + 16'($urandom_range(140));
        c.command = CMD_POS;
        c.target_count = $urandom;
        c.encoder_count = c.target_count - delta;
        c.count_tolerance = 31'($urandom_range(60));
        c.encoder_speed = int'($urandom_range(2 * SPEED_SPAN)) - SPEED_SPAN;
        c.target_speed = int'($urandom_range(2 * SPEED_SPAN)) - SPEED_SPAN;
        c.speed_tolerance = 31'($urandom_range(TOL_SPAN));
        c.now_tick = tick_now;
        if ($urandom_range(9) == 0) begin
            c.count_tolerance = 31'($urandom_range(300));
        end
        if (pick >= 88) begin
            c.command = 2'($urandom);
            c.target_count = $urandom;
            c.encoder_count = $urandom;
            c.count_tolerance = 31'($urandom);
            c.encoder_speed = $urandom;
            c.target_speed = $urandom;
            c.speed_tolerance = 31'($urandom);
            c.now_tick = 16'($urandom);
        end else if (pick >= 85) begin
            c.command = CMD_UNUSED;
        end else if (pick >= 80) begin
            c.command = CMD_CLR;
        end else if (pick >= 45) begin
            c.command = CMD_SPD;
        end
        return c;
    endfunction

    function automatic t_motor_cmd pos_step(input logic signed [31:0] tgt,
                                            input logic signed [31:0] enc,
                                            input logic [30:0] tol,
                                            input logic [15:0] tick,
                                            input logic signed [31:0] espd);
        t_motor_cmd c;
        c = make_cmd();
        c.command = CMD_POS;
        c.target_count = tgt;
        c.encoder_count = enc;
        c.count_tolerance = tol;
        c.now_tick = tick;
        c.encoder_speed = espd;
        return c;
    endfunction

    function automatic t_motor_cmd spd_step(input logic signed [31:0] espd,
                                            input logic signed [31:0] tspd,
                                            input logic [30:0] tol,
                                            input logic [15:0] tick);
        t_motor_cmd c;
        c = make_cmd();
        c.command = CMD_SPD;
        c.encoder_speed = espd;
        c.target_speed = tspd;
        c.speed_tolerance = tol;
        c.now_tick = tick;
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KP_POS:  gains.kp_pos = value;
            REG_KI_POS:  gains.ki_pos = value;
            REG_KD_POS:  gains.kd_pos = value;
            REG_KP_SPD:  gains.kp_spd = value;
            REG_KI_SPD:  gains.ki_spd = value;
            REG_POS_LIM: gains.pos_lim = value[30:0];
            REG_SPD_LIM: gains.spd_lim = value[30:0];
            REG_CTA:     gains.cta = value;
            default: begin
            end
        endcase
    endtask

    task automatic load_gains(input t_gain_set kind);
        logic [31:0] v [8];
        case (kind)
            GAINS_MILD: begin
                v[REG_KP_POS] = 32'h0001_0000;
                v[REG_KI_POS] = 32'h0000_4000;
                v[REG_KD_POS] = 32'h0000_1000;
                v[REG_KP_SPD] = 32'h0000_8000;
                v[REG_KI_SPD] = 32'h0000_0400;
                v[REG_POS_LIM] = 32'd500;
                v[REG_SPD_LIM] = 32'h0100_0000;
                v[REG_CTA] = 32'h0002_0000;
            end
            GAINS_RANDOM: begin
                v[REG_KP_POS] = $urandom_range(1 << 21) - (1 << 20);
                v[REG_KI_POS] = $urandom_range(1 << 17) - (1 << 16);
                v[REG_KD_POS] = $urandom_range(1 << 21) - (1 << 20);
                v[REG_KP_SPD] = $urandom_range(1 << 21) - (1 << 20);
                v[REG_KI_SPD] = $urandom_range(1 << 17) - (1 << 16);
                v[REG_POS_LIM] = {1'($urandom), 31'($urandom_range(1 << 12))};
                v[REG_SPD_LIM] = {1'($urandom), 31'($urandom_range(1 << 28))};
                v[REG_CTA] = $urandom_range(1 << 19) - (1 << 18);
            end
            GAINS_TOP: begin
                foreach (v[i]) v[i] = 32'h7FFF_FFFF;
            end
            GAINS_BOTTOM: begin
                foreach (v[i]) v[i] = 32'h8000_0000;
            end
            GAINS_ZERO: begin
                foreach (v[i]) v[i] = '0;
            end
            default: begin
                foreach (v[i]) v[i] = $urandom;
            end
        endcase
        write_reg(REG_KP_POS, v[REG_KP_POS]);
        write_reg(REG_KI_POS, v[REG_KI_POS]);
        write_reg(REG_KD_POS, v[REG_KD_POS]);
        write_reg(REG_KP_SPD, v[REG_KP_SPD]);
        write_reg(REG_KI_SPD, v[REG_KI_SPD]);
        write_reg(REG_POS_LIM, v[REG_POS_LIM]);
        write_reg(REG_SPD_LIM, v[REG_SPD_LIM]);
        write_reg(REG_CTA, v[REG_CTA]);
        gain_loads++;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d drive beats outstanding.", expected_drives.size());
        $display("motor_position_speed_pid_core test failed");
        $finish;
    end

    always @(negedge i_clk) begin
        t_motor_cmd nxt;
        logic       send;
        send = 1'b0;
        if (i_rst_n) begin
            drive_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
            if (!cmd_bus.valid || beat_taken) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending_cmds.pop_front();
                    send = 1'b1;
                    cmd_bus.command <= nxt.command;
                    cmd_bus.target_count <= nxt.target_count;
                    cmd_bus.count_tolerance <= nxt.count_tolerance;
                    cmd_bus.encoder_count <= nxt.encoder_count;
                    cmd_bus.encoder_speed <= nxt.encoder_speed;
                    cmd_bus.target_speed <= nxt.target_speed;
                    cmd_bus.speed_tolerance <= nxt.speed_tolerance;
                    cmd_bus.now_tick <= nxt.now_tick;
                end
                cmd_bus.valid <= send;
            end
        end
    end

    always @(posedge i_clk) begin
        t_drive_result want;
        t_motor_cmd    seen;
        if (i_rst_n) begin
            if (drive_bus.valid && drive_bus.ready) begin
                if (drive_bus.brake === 1'b1) brake_count++;
                if (drive_bus.drive === DRIVE_TOP || drive_bus.drive === DRIVE_FLOOR) begin
                    sat_count++;
                end
                if (expected_drives.size() == 0) begin
                    $error("drive beat with no command waiting: drive %0d brake %0b",
                           drive_bus.drive, drive_bus.brake);
                    error_count++;
                end else begin
                    want = expected_drives.pop_front();
                    if (drive_bus.drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, drive_bus.drive);
                        error_count++;
                    end
                    if (drive_bus.brake !== want.brake) begin
                        $error("brake: expected %0b, got %0b", want.brake, drive_bus.brake);
                        error_count++;
                    end
                end
            end
            beat_taken = cmd_bus.valid && cmd_bus.ready;
            if (beat_taken) begin
                seen.command = cmd_bus.command;
                seen.target_count = cmd_bus.target_count;
                seen.count_tolerance = cmd_bus.count_tolerance;
                seen.encoder_count = cmd_bus.encoder_count;
                seen.encoder_speed = cmd_bus.encoder_speed;
                seen.target_speed = cmd_bus.target_speed;
                seen.speed_tolerance = cmd_bus.speed_tolerance;
                seen.now_tick = cmd_bus.now_tick;
                expected_drives.push_back(predict_drive(seen));
                cmd_counts[seen.command]++;
            end
        end
    end

    initial begin
        t_gain_set   plan [8];
        int unsigned src_mix [4];
        int unsigned snk_mix [4];
        t_motor_cmd  c;
        plan = '{GAINS_RANDOM, GAINS_TOP, GAINS_RANDOM, GAINS_BOTTOM,
                 GAINS_WILD, GAINS_RANDOM, GAINS_ZERO, GAINS_RANDOM};
        src_mix = '{0, 83, 0, 17};
        snk_mix = '{0, 0, 83, 17};
        gains = '0;
        gains.cta = CTA_RESET;
        last_gate_tick = '0;
        pos_integral = '0;
        spd_integral = '0;
        filtered_speed = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_POS;
        cmd_bus.target_count = '0;
        cmd_bus.count_tolerance = '0;
        cmd_bus.encoder_count = '0;
        cmd_bus.encoder_speed = '0;
        cmd_bus.target_speed = '0;
        cmd_bus.speed_tolerance = '0;
        cmd_bus.now_tick = '0;
        drive_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_gains(GAINS_MILD);
        pending_cmds.push_back(pos_step(1000, 799, 0, 0, 0));
        pending_cmds.push_back(pos_step(1000, 1201, 0, 0, 0));
        pending_cmds.push_back(pos_step(0, -200, 0, 100, 32'sh0001_0000));
        pending_cmds.push_back(pos_step(0, 200, 0, 150, -32'sh0001_0000));
        pending_cmds.push_back(pos_step(5, 5, 0, 160, 0));
        pending_cmds.push_back(pos_step(-7, -2, 5, 170, 0));
        pending_cmds.push_back(pos_step(-7, -1, 5, 250, 0));
        pending_cmds.push_back(pos_step(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 260, 0));
        pending_cmds.push_back(pos_step(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 270, 0));
        pending_cmds.push_back(pos_step(10, 0, 31'h7FFF_FFFF, 280, 0));
        pending_cmds.push_back(pos_step(100, 0, 0, 16'd65530, 32'sh7FFF_FFFF));
        pending_cmds.push_back(pos_step(-100, 0, 0, 20, 32'sh8000_0000));
        pending_cmds.push_back(pos_step(-100, 0, 0, 200, 0));
        pending_cmds.push_back(spd_step(32'sh000A_0000, 32'sh001E_0000, 0, 400));
        pending_cmds.push_back(spd_step(32'sh000A_0000, 32'sh0014_0000, 31'h7FFF_FFFF, 600));
        pending_cmds.push_back(spd_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 800));
        pending_cmds.push_back(spd_step(32'sh8000_0000, 32'sh8000_0000, 0, 900));
        pending_cmds.push_back(spd_step(0, 0, 0, 950));
        c = make_cmd();
        c.command = CMD_CLR;
        pending_cmds.push_back(c);
        c = make_cmd();
        c.command = CMD_UNUSED;
        pending_cmds.push_back(c);
        pending_cmds.push_back(pos_step(0, 3, 0, 1100, 0));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            load_gains(plan[ph]);
            src_idle_pct = src_mix[ph % 4];
            snk_stall_pct = snk_mix[ph % 4];
            for (int k = 0; k < 4; k++) begin
                repeat (CHUNK_ITEMS) pending_cmds.push_back(make_cmd());
                wait_drained();
            end
        end

        $display("Checked %0d position, %0d speed, %0d clear and %0d unused commands.",
                 cmd_counts[CMD_POS], cmd_counts[CMD_SPD], cmd_counts[CMD_CLR],
                 cmd_counts[CMD_UNUSED]);
        $display("%0d gain settings with gaps and stalls on both sides; %0d brakes, %0d %s",
                 gain_loads, brake_count, sat_count, "at drive limit.");
        if (error_count == 0) begin
            $display("motor_position_speed_pid_core test passed");
        end else begin
            $display("motor_position_speed_pid_core test failed");
        end
        $finish;
    end

endmodule

### motor_position_speed_pid_core.f
+incdir+hw/rtl
hw/rtl/mpsp_pkg.sv
hw/rtl/mpsp_in_if.sv
hw/rtl/mpsp_out_if.sv
hw/rtl/mpsp_apb_regs.sv
hw/rtl/mpsp_mac.sv
hw/rtl/motor_position_speed_pid_core.sv
test/testbench.sv
